### sv/mstt_pkg.sv
`default_nettype none

package mstt_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int IDX_OUT_W  = 4;
  localparam int ID_W       = 31;
  localparam int TIME_W     = 48;
  localparam int DELAY_W    = 32;
  localparam int KIND_W     = 3;

  typedef enum logic [1:0] {
    OP_SET_ONCE     = 2'd0,
    OP_SET_PERIODIC = 2'd1,
    OP_CLEAR        = 2'd2,
    OP_TICK         = 2'd3
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    RK_ASSIGNED = 3'd0,
    RK_FULL     = 3'd1,
    RK_CLEARED  = 3'd2,
    RK_FIRED    = 3'd3,
    RK_NONE     = 3'd4
  } result_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET,
    ST_CLR,
    ST_CLR_OUT,
    ST_TSCAN,
    ST_TFIRE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [ID_W-1:0]   period;
    logic [TIME_W-1:0] fire;
  } entry_t;

  // Add a 31-bit offset to a 48-bit time, saturating at all ones.
  function automatic logic [TIME_W-1:0] add_sat48(input logic [TIME_W-1:0] a,
                                                   input logic [ID_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + (TIME_W+1)'(b);
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/multi_slot_timer_table_top.sv
`default_nettype none

// Timer slot table with sixteen one-shot or periodic slots. Issue a command by
// raising start with opcode, delay_value, clear_id and now_time while busy is
// low; the transfer happens at that clock edge. Results come out one per cycle
// on result_strobe and cannot be held off, so the receiver must take every
// strobed cycle; last marks the final result of a command and any_active shows
// whether any slot is still armed once the whole command is done. A set writes
// its slot in ST_SET and answers through the output registers. A clear and a
// tick walk the slot memory one entry per cycle through its single read port;
// a clear stops at the matching id, and a tick makes a second walk only when
// slots have expired: the first finds them and settles any_active, the second
// reports them and re-arms periodic slots. Busy drops in the cycle the last
// result is on the ports.

module multi_slot_timer_table_top
  import mstt_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  output logic                    busy,
  input  wire  [1:0]              opcode,
  input  wire  signed [DELAY_W-1:0] delay_value,
  input  wire  [ID_W-1:0]         clear_id,
  input  wire  [TIME_W-1:0]       now_time,
  output logic                    result_strobe,
  output logic [KIND_W-1:0]       result_kind,
  output logic [ID_W-1:0]         timer_id,
  output logic [IDX_OUT_W-1:0]    slot_index,
  output logic                    any_active,
  output logic                    last
);

  // Slot memory: id, period and fire time; one write and one read port.
  entry_t mem [SLOT_COUNT];
  entry_t rd_q;
  logic   rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic   mem_we;
  logic [SLOT_W-1:0] wr_addr;
  entry_t wr_data;

  state_t state, state_next;

  // Per-slot flags live in flops so set and any_active need no memory read.
  logic [SLOT_COUNT-1:0] slot_active, slot_active_next;
  logic [SLOT_COUNT-1:0] slot_periodic, slot_periodic_next;
  logic [SLOT_COUNT-1:0] exp_mask, exp_mask_next;
  logic [ID_W-1:0]       id_counter, id_counter_next;

  // Command held for the length of the walk.
  opcode_t           op_q, op_q_next;
  logic [ID_W-1:0]   delay_q, delay_q_next;
  logic [ID_W-1:0]   cid_q, cid_q_next;
  logic [TIME_W-1:0] now_q, now_q_next;

  // Walk control: scan_idx is the address issued, chk_idx the one returning.
  logic [SLOT_W-1:0] scan_idx, scan_idx_next;
  logic              issue_on, issue_on_next;
  logic [SLOT_W-1:0] chk_idx;
  logic              chk_vld;

  logic                 strobe_next;
  result_kind_t         kind_next;
  logic [ID_W-1:0]      tid_next;
  logic [IDX_OUT_W-1:0] sidx_next;
  logic                 any_next;
  logic                 last_next;

  logic [SLOT_W-1:0]     free_idx;
  logic [SLOT_COUNT-1:0] exp_upd;
  logic [SLOT_COUNT-1:0] exp_rest;
  logic [SLOT_COUNT-1:0] active_after;
  logic [TIME_W-1:0]     fire_sum;
  logic                  accept;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_active[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next         = state;
    slot_active_next   = slot_active;
    slot_periodic_next = slot_periodic;
    exp_mask_next      = exp_mask;
    id_counter_next    = id_counter;
    op_q_next          = op_q;
    delay_q_next       = delay_q;
    cid_q_next         = cid_q;
    now_q_next         = now_q;
    scan_idx_next      = scan_idx;
    issue_on_next      = issue_on;
    rd_en              = 1'b0;
    rd_addr            = scan_idx;
    mem_we             = 1'b0;
    wr_addr            = chk_idx;
    wr_data            = rd_q;
    strobe_next        = 1'b0;
    kind_next          = RK_NONE;
    tid_next           = '0;
    sidx_next          = '0;
    any_next           = 1'b0;
    last_next          = 1'b0;
    exp_upd            = exp_mask;
    exp_rest           = exp_mask;
    active_after       = slot_active;
    fire_sum           = add_sat48(rd_q.fire, rd_q.period);

    // Issue one read per cycle during a walk.
    if ((state == ST_CLR || state == ST_TSCAN || state == ST_TFIRE) && issue_on) begin
      rd_en         = 1'b1;
      scan_idx_next = scan_idx + 1'b1;
      issue_on_next = (scan_idx != LAST_SLOT);
    end

    case (state)
      ST_IDLE: begin
        if (accept) begin
          op_q_next     = opcode_t'(opcode);
          delay_q_next  = delay_value[DELAY_W-1] ? '0 : delay_value[ID_W-1:0];
          cid_q_next    = clear_id;
          now_q_next    = now_time;
          scan_idx_next = '0;
          exp_mask_next = '0;
          case (opcode_t'(opcode))
            OP_SET_ONCE, OP_SET_PERIODIC: begin
              issue_on_next = 1'b0;
              state_next    = ST_SET;
            end
            OP_CLEAR: begin
              issue_on_next = 1'b1;
              state_next    = ST_CLR;
            end
            default: begin
              issue_on_next = 1'b1;
              state_next    = ST_TSCAN;
            end
          endcase
        end
      end

      ST_SET: begin
        strobe_next = 1'b1;
        any_next    = 1'b1;
        last_next   = 1'b1;
        state_next  = ST_IDLE;
        if (&slot_active) begin
          kind_next = RK_FULL;
        end else begin
          mem_we                       = 1'b1;
          wr_addr                      = free_idx;
          wr_data.id                   = id_counter;
          wr_data.period               = delay_q;
          wr_data.fire                 = add_sat48(now_q, delay_q);
          slot_active_next[free_idx]   = 1'b1;
          slot_periodic_next[free_idx] = (op_q == OP_SET_PERIODIC);
          id_counter_next              = id_counter + 1'b1;
          kind_next                    = RK_ASSIGNED;
          tid_next                     = id_counter;
          sidx_next                    = IDX_OUT_W'(free_idx);
        end
      end

      ST_CLR: begin
        if (chk_vld && slot_active[chk_idx] && (rd_q.id == cid_q)) begin
          slot_active_next[chk_idx] = 1'b0;
          issue_on_next             = 1'b0;
          state_next                = ST_CLR_OUT;
        end else if (chk_vld && chk_idx == LAST_SLOT) begin
          state_next = ST_CLR_OUT;
        end
      end

      ST_CLR_OUT: begin
        strobe_next = 1'b1;
        kind_next   = RK_CLEARED;
        any_next    = |slot_active;
        last_next   = 1'b1;
        state_next  = ST_IDLE;
      end

      ST_TSCAN: begin
        if (chk_vld && slot_active[chk_idx] && (now_q >= rd_q.fire)) begin
          exp_upd[chk_idx] = 1'b1;
        end
        exp_mask_next = exp_upd;
        if (chk_vld && chk_idx == LAST_SLOT) begin
          // Drop expired one-shots now so any_active is known for every result.
          active_after     = slot_active & ~(exp_upd & ~slot_periodic);
          slot_active_next = active_after;
          if (exp_upd == '0) begin
            strobe_next = 1'b1;
            kind_next   = RK_NONE;
            any_next    = |slot_active;
            last_next   = 1'b1;
            state_next  = ST_IDLE;
          end else begin
            scan_idx_next = '0;
            issue_on_next = 1'b1;
            state_next    = ST_TFIRE;
          end
        end
      end

      ST_TFIRE: begin
        if (chk_vld && exp_mask[chk_idx]) begin
          exp_rest[chk_idx] = 1'b0;
          exp_mask_next     = exp_rest;
          strobe_next       = 1'b1;
          kind_next         = RK_FIRED;
          tid_next          = rd_q.id;
          sidx_next         = IDX_OUT_W'(chk_idx);
          any_next          = |slot_active;
          last_next         = (exp_rest == '0);
          if (slot_periodic[chk_idx]) begin
            // Advance by one period, never behind now.
            mem_we       = 1'b1;
            wr_addr      = chk_idx;
            wr_data.fire = (fire_sum < now_q) ? now_q : fire_sum;
          end
          if (exp_rest == '0) begin
            issue_on_next = 1'b0;
            state_next    = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active   <= '0;
      slot_periodic <= '0;
      id_counter    <= ID_W'(1);
      issue_on      <= 1'b0;
      chk_vld       <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      slot_active   <= slot_active_next;
      slot_periodic <= slot_periodic_next;
      id_counter    <= id_counter_next;
      issue_on      <= issue_on_next;
      chk_vld       <= rd_en;
      result_strobe <= strobe_next;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    exp_mask    <= exp_mask_next;
    op_q        <= op_q_next;
    delay_q     <= delay_q_next;
    cid_q       <= cid_q_next;
    now_q       <= now_q_next;
    scan_idx    <= scan_idx_next;
    chk_idx     <= rd_addr;
    result_kind <= kind_next;
    timer_id    <= tid_next;
    slot_index  <= sidx_next;
    any_active  <= any_next;
    last        <= last_next;
  end

  // A set always answers as the last result, registered out of ST_SET.
  a_set_answers: assert property (@(posedge clk) disable iff (rst)
    (accept && (opcode == OP_SET_ONCE || opcode == OP_SET_PERIODIC))
      |-> ##2 (result_strobe && last))
    else $error("set did not answer in two cycles");

  // Results only come from a command in flight.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy))
    else $error("result with no command in flight");

  // A full table means every slot is armed.
  a_full_active: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result_kind == RK_FULL) |-> any_active)
    else $error("table full reported with no active slot");

  // A fired result always refers to a slot still being walked in the fire pass.
  a_fire_walk: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result_kind == RK_FIRED) |-> $past(state == ST_TFIRE))
    else $error("fired result outside the fire pass");

endmodule

`default_nettype wire
